FILE: design/sfpx_pkg.sv
`timescale 1ns / 1ps

package sfpx_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 5;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 3;
    localparam int PHASE_W  = 3;

    // The payload index is four bits wide, so no frame may carry more than this.
    localparam int POS_SPAN        = 16;
    localparam int DEFAULT_MAX_LEN = 16;

    localparam int QUEUE_DEPTH = 2;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_MARKER = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_LIMIT = 1'd1;

    localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'hAA;
    localparam logic [LEN_W-1:0]  LENGTH_LIMIT_RESET = 5'd16;

    localparam logic [PHASE_W-1:0] PH_HUNT = 3'd0;
    localparam logic [PHASE_W-1:0] PH_CMD  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEN  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DATA = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SUM  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DISCARD = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HEADER  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PAYLOAD = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BADLEN  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADSUM  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_GOOD    = 3'd5;

    // A received byte together with the checks that do not depend on parser state.
    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              is_start;
        logic              len_ok;
    } t_item;

endpackage

FILE: design/sfpx_front.sv
`timescale 1ns / 1ps

module sfpx_front #(
    parameter int MAX_LEN = sfpx_pkg::DEFAULT_MAX_LEN
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sfpx_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [sfpx_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [sfpx_pkg::BYTE_W-1:0]         i_rx_byte,
    output logic                                o_q_valid,
    output sfpx_pkg::t_item                     o_q_item,
    input  logic                                i_q_pop
);

    localparam int Depth  = sfpx_pkg::QUEUE_DEPTH;
    localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CountW = $clog2(Depth + 1);
    localparam int CapInt = (MAX_LEN < sfpx_pkg::POS_SPAN) ? MAX_LEN : sfpx_pkg::POS_SPAN;
    localparam logic [sfpx_pkg::LEN_W-1:0] LimCap = sfpx_pkg::LEN_W'(CapInt);

    logic [sfpx_pkg::BYTE_W-1:0] r_start_marker;
    logic [sfpx_pkg::LEN_W-1:0]  r_length_limit;

    sfpx_pkg::t_item             r_mem [Depth];
    logic [PtrW-1:0]             r_wr_ptr;
    logic [PtrW-1:0]             r_rd_ptr;
    logic [CountW-1:0]           r_count;

    logic [sfpx_pkg::LEN_W-1:0]  w_eff_limit;
    sfpx_pkg::t_item             w_item;
    logic                        w_push;
    logic                        w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= sfpx_pkg::START_MARKER_RESET;
            r_length_limit <= sfpx_pkg::LENGTH_LIMIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sfpx_pkg::CFG_START_MARKER: r_start_marker <= i_cfg_data;
                sfpx_pkg::CFG_LENGTH_LIMIT: r_length_limit <= i_cfg_data[sfpx_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // The accepted maximum is the smallest of the register, the build limit and the index span.
    assign w_eff_limit = (r_length_limit < LimCap) ? r_length_limit : LimCap;

    always_comb begin
        w_item.rx_byte  = i_rx_byte;
        w_item.is_start = (i_rx_byte == r_start_marker);
        w_item.len_ok   = (i_rx_byte <=
                           {{(sfpx_pkg::BYTE_W - sfpx_pkg::LEN_W){1'b0}}, w_eff_limit});
    end

    assign o_in_stall = (r_count == CountW'(Depth));
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != '0);
    assign w_pop      = i_q_pop && o_q_valid;
    assign o_q_item   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + PtrW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + PtrW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CountW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CountW'(1);
            end
        end
    end

endmodule

FILE: design/sfpx_back.sv
`timescale 1ns / 1ps

module sfpx_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  sfpx_pkg::t_item                     i_q_item,
    output logic                                o_q_pop,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [sfpx_pkg::STATUS_W-1:0]       o_status,
    output logic                                o_frame_ok,
    output logic [sfpx_pkg::BYTE_W-1:0]         o_command,
    output logic [sfpx_pkg::LEN_W-1:0]          o_length,
    output logic [sfpx_pkg::BYTE_W-1:0]         o_payload_data,
    output logic [sfpx_pkg::POS_W-1:0]          o_payload_index
);

    logic [sfpx_pkg::PHASE_W-1:0]  r_phase,   n_phase;
    logic [sfpx_pkg::BYTE_W-1:0]   r_command, n_command;
    logic [sfpx_pkg::LEN_W-1:0]    r_length,  n_length;
    logic [sfpx_pkg::POS_W-1:0]    r_pos,     n_pos;
    logic [sfpx_pkg::BYTE_W-1:0]   r_xor,     n_xor;

    logic                          r_out_valid;
    logic [sfpx_pkg::STATUS_W-1:0] r_status,  n_status;
    logic [sfpx_pkg::BYTE_W-1:0]   r_pdata,   n_pdata;
    logic [sfpx_pkg::POS_W-1:0]    r_pidx,    n_pidx;

    logic [sfpx_pkg::LEN_W-1:0]    w_pos_inc;
    logic [sfpx_pkg::BYTE_W-1:0]   w_byte;

    // A new transaction is taken whenever the output register is empty or is being emptied.
    assign o_q_pop   = i_q_valid && (!r_out_valid || !i_out_stall);
    assign w_byte    = i_q_item.rx_byte;
    assign w_pos_inc = {1'b0, r_pos} + sfpx_pkg::LEN_W'(1);

    always_comb begin
        n_phase   = r_phase;
        n_command = r_command;
        n_length  = r_length;
        n_pos     = r_pos;
        n_xor     = r_xor;
        n_status  = sfpx_pkg::ST_DISCARD;
        n_pdata   = '0;
        n_pidx    = '0;
        unique case (r_phase)
            sfpx_pkg::PH_CMD: begin
                n_command = w_byte;
                n_xor     = r_xor ^ w_byte;
                n_phase   = sfpx_pkg::PH_LEN;
                n_status  = sfpx_pkg::ST_HEADER;
            end
            sfpx_pkg::PH_LEN: begin
                if (i_q_item.len_ok) begin
                    n_length = w_byte[sfpx_pkg::LEN_W-1:0];
                    n_xor    = r_xor ^ w_byte;
                    n_pos    = '0;
                    n_phase  = (w_byte == '0) ? sfpx_pkg::PH_SUM : sfpx_pkg::PH_DATA;
                    n_status = sfpx_pkg::ST_HEADER;
                end else begin
                    n_xor    = '0;
                    n_phase  = sfpx_pkg::PH_HUNT;
                    n_status = sfpx_pkg::ST_BADLEN;
                end
            end
            sfpx_pkg::PH_DATA: begin
                n_xor    = r_xor ^ w_byte;
                n_pdata  = w_byte;
                n_pidx   = r_pos;
                n_status = sfpx_pkg::ST_PAYLOAD;
                if (w_pos_inc >= r_length) begin
                    n_pos   = '0;
                    n_phase = sfpx_pkg::PH_SUM;
                end else begin
                    n_pos   = w_pos_inc[sfpx_pkg::POS_W-1:0];
                end
            end
            sfpx_pkg::PH_SUM: begin
                n_status = (w_byte == r_xor) ? sfpx_pkg::ST_GOOD : sfpx_pkg::ST_BADSUM;
                n_xor    = '0;
                n_phase  = sfpx_pkg::PH_HUNT;
            end
            default: begin
                n_phase = sfpx_pkg::PH_HUNT;
                if (i_q_item.is_start) begin
                    n_xor    = '0;
                    n_pos    = '0;
                    n_phase  = sfpx_pkg::PH_CMD;
                    n_status = sfpx_pkg::ST_HEADER;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= sfpx_pkg::PH_HUNT;
            r_command   <= '0;
            r_length    <= '0;
            r_pos       <= '0;
            r_xor       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_phase   <= n_phase;
                r_command <= n_command;
                r_length  <= n_length;
                r_pos     <= n_pos;
                r_xor     <= n_xor;
            end
            if (o_q_pop) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_status <= n_status;
            r_pdata  <= n_pdata;
            r_pidx   <= n_pidx;
        end
    end

    // Command and length in the result are the held values after the byte, so they
    // follow the state registers that were loaded together with the result.
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_frame_ok      = (r_status == sfpx_pkg::ST_GOOD);
    assign o_command       = r_command;
    assign o_length        = r_length;
    assign o_payload_data  = r_pdata;
    assign o_payload_index = r_pidx;

endmodule

FILE: design/serial_frame_parser_xor.sv
`timescale 1ns / 1ps

// Channel     Direction  Handshake                    Payload
// config      in         i_cfg_we                     i_cfg_index, i_cfg_data
// byte in     in         i_in_valid / o_in_stall      i_rx_byte
// result out  out        o_out_valid / i_out_stall    o_status, o_frame_ok, o_command,
//                                                     o_length, o_payload_data, o_payload_index
//
// One byte is accepted every cycle and one result leaves every cycle while the output
// is not stalled; each byte is held in the front queue, then its result in the output register.
// The parser state in the back part is updated once per byte, which sets that rate.
// Reset is synchronous and active low; it empties the queue and returns the parser to hunting.
// A stalled output holds its result; the two-entry queue then fills and stalls the input.

module serial_frame_parser_xor #(
    parameter int MAX_LEN = sfpx_pkg::DEFAULT_MAX_LEN
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [sfpx_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [sfpx_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [sfpx_pkg::BYTE_W-1:0]         i_rx_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [sfpx_pkg::STATUS_W-1:0]       o_status,
    output logic                                o_frame_ok,
    output logic [sfpx_pkg::BYTE_W-1:0]         o_command,
    output logic [sfpx_pkg::LEN_W-1:0]          o_length,
    output logic [sfpx_pkg::BYTE_W-1:0]         o_payload_data,
    output logic [sfpx_pkg::POS_W-1:0]          o_payload_index
);

    logic            w_q_valid;
    sfpx_pkg::t_item w_q_item;
    logic            w_q_pop;

    sfpx_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .o_q_valid   (w_q_valid),
        .o_q_item    (w_q_item),
        .i_q_pop     (w_q_pop)
    );

    sfpx_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_valid       (w_q_valid),
        .i_q_item        (w_q_item),
        .o_q_pop         (w_q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_frame_ok      (o_frame_ok),
        .o_command       (o_command),
        .o_length        (o_length),
        .o_payload_data  (o_payload_data),
        .o_payload_index (o_payload_index)
    );

endmodule
